### rtl/gred_pkg.sv
// Package for the gated rotary encoder decoder: word types of the request and
// response channels, register indexes, register reset values and turn codes.
// Depends on nothing; used by gated_rotary_encoder_decoder_core.
package gred_pkg;

   // Configuration register file.
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_ADDR_WIDTH = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ALLOW_TICKS  = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_WINDOW_TICKS = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] ALLOW_TICKS_RESET  = 16'd1000;
   localparam logic [CSR_DATA_WIDTH-1:0] WINDOW_TICKS_RESET = 16'd20;

   // Turn codes reported on the response channel.
   localparam logic [1:0] TURN_NONE = 2'd0;
   localparam logic [1:0] TURN_CW   = 2'd1;
   localparam logic [1:0] TURN_CCW  = 2'd2;

   typedef struct packed {
      logic button;
      logic chan_a;
      logic chan_b;
   } req_type;

   typedef struct packed {
      logic       led_on;
      logic [1:0] turn;
      logic       turn_ignored;
   } rsp_type;

endpackage

### rtl/gated_rotary_encoder_decoder_core.sv
// Gated quadrature rotary encoder decoder, top level. Depends on gred_pkg.
//
// Usage: each request word carries one sample tick of the push-button and the
// encoder channels A and B. Every request word produces exactly one response
// word with the LED level, the turn reported on that tick and a flag for a
// turn that was dropped because the input window was closed.
// Both channels use valid/ready; a word moves when valid and ready are high
// at the same rising edge. The csr_ port writes allow_ticks (index 0) and
// window_ticks (index 1) whenever csr_we is high; it must only be used while
// no word is in flight.
// Flow: a request word is registered in the input register when accepted,
// and its response word is registered in the response register once that
// register is free; rsp_valid comes from the response register. Throughput
// is one word per cycle while the receiver does not stall; the counter state
// is updated between the two registers.
// Reset (synchronous, active high) empties both registers, closes all windows,
// turns the LED off and restores the register defaults (1000 and 20).
// When the receiver stalls, the response word holds and the input register
// still takes one more word; further words wait with req_ready low.
module gated_rotary_encoder_decoder_core
   import gred_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,

   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   // Largest value a counter can hold; register values above it saturate.
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] allow_ticks_ff;
   logic [CSR_DATA_WIDTH-1:0] window_ticks_ff;

   // Input register.
   logic    in_valid_ff;
   req_type in_word_ff;

   // Response register.
   logic    out_valid_ff;
   rsp_type out_word_ff;
   rsp_type out_word_in;

   // Decoder state.
   logic                   last_a_ff, last_a_in;
   logic                   last_b_ff, last_b_in;
   logic                   led_ff, led_in;
   logic [COUNT_WIDTH-1:0] allow_count_ff, allow_count_in;
   logic [COUNT_WIDTH-1:0] cw_count_ff, cw_count_in;
   logic [COUNT_WIDTH-1:0] ccw_count_ff, ccw_count_in;

   logic                   advance;
   logic [COUNT_WIDTH-1:0] allow_load;
   logic [COUNT_WIDTH-1:0] window_load;

   // The input register moves into the response register whenever that
   // register is empty or its word is being taken this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // Window reload values: saturate to the counter range, and treat a zero
   // register as a length of one.
   function automatic logic [COUNT_WIDTH-1:0] load_value(
      input logic [CSR_DATA_WIDTH-1:0] ticks
   );
      logic [31:0] wide;
      wide = 32'(ticks);
      if (wide > COUNT_MAX) begin
         wide = COUNT_MAX;
      end
      if (wide == 32'd0) begin
         wide = 32'd1;
      end
      return wide[COUNT_WIDTH-1:0];
   endfunction

   assign allow_load  = load_value(allow_ticks_ff);
   assign window_load = load_value(window_ticks_ff);

   // One tick of the decoder. All counters first count down, then a press
   // opens the input window, then channel A is handled before channel B, so
   // that a B edge can complete a detent whose CW window A opened on the same
   // tick. A detected turn passes only while the input window is open and
   // then restarts that window.
   always_comb begin
      logic [1:0] detected;
      logic       a_rise;
      logic       b_fall;

      detected = TURN_NONE;
      a_rise   = in_word_ff.chan_a && !last_a_ff;
      b_fall   = !in_word_ff.chan_b && last_b_ff;

      allow_count_in = (allow_count_ff != '0) ? allow_count_ff - COUNT_ONE : '0;
      cw_count_in    = (cw_count_ff != '0) ? cw_count_ff - COUNT_ONE : '0;
      ccw_count_in   = (ccw_count_ff != '0) ? ccw_count_ff - COUNT_ONE : '0;
      led_in         = (allow_count_in == '0) ? 1'b0 : led_ff;

      if (in_word_ff.button) begin
         allow_count_in = allow_load;
         led_in         = 1'b1;
      end

      if (a_rise) begin
         if (ccw_count_in != '0) begin
            detected     = TURN_CCW;
            ccw_count_in = '0;
         end else if (cw_count_in == '0) begin
            cw_count_in = window_load;
         end
      end

      if (b_fall) begin
         if (cw_count_in != '0) begin
            detected    = TURN_CW;
            cw_count_in = '0;
         end else if (ccw_count_in == '0) begin
            ccw_count_in = window_load;
         end
      end

      last_a_in = in_word_ff.chan_a;
      last_b_in = in_word_ff.chan_b;

      out_word_in.turn         = TURN_NONE;
      out_word_in.turn_ignored = 1'b0;
      if (detected != TURN_NONE) begin
         if (allow_count_in != '0) begin
            allow_count_in   = allow_load;
            out_word_in.turn = detected;
         end else begin
            out_word_in.turn_ignored = 1'b1;
         end
      end
      out_word_in.led_on = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ticks_ff  <= ALLOW_TICKS_RESET;
         window_ticks_ff <= WINDOW_TICKS_RESET;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_a_ff       <= 1'b0;
         last_b_ff       <= 1'b0;
         led_ff          <= 1'b0;
         allow_count_ff  <= '0;
         cw_count_ff     <= '0;
         ccw_count_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ALLOW_TICKS:  allow_ticks_ff  <= csr_wdata;
               CSR_WINDOW_TICKS: window_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (req_ready) begin
            in_valid_ff <= req_valid;
         end

         if (advance) begin
            out_valid_ff   <= 1'b1;
            last_a_ff      <= last_a_in;
            last_b_ff      <= last_b_in;
            led_ff         <= led_in;
            allow_count_ff <= allow_count_in;
            cw_count_ff    <= cw_count_in;
            ccw_count_ff   <= ccw_count_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule
